// ===== src/modexp_pkg.sv =====
`timescale 1ns / 1ps
package modexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RED  = 4'b0010,
    S_LOOP = 4'b0100,
    S_MUL  = 4'b1000
  } state_t;

endpackage

// ===== src/modexp_mulmod.sv =====
`timescale 1ns / 1ps
module modexp_mulmod (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  modexp_pkg::word_t   a,
  input  modexp_pkg::word_t   b,
  input  modexp_pkg::word_t   m,
  output logic                done,
  output modexp_pkg::word_t   p
);

  modexp_pkg::word_t              aq;
  modexp_pkg::word_t              bq;
  modexp_pkg::word_t              r;
  modexp_pkg::word_t              r_next;
  logic [modexp_pkg::CNT_W-1:0]   cnt;
  logic                           active;

  logic [modexp_pkg::WIDTH:0] dbl;
  logic [modexp_pkg::WIDTH:0] dbl_red;
  logic [modexp_pkg::WIDTH:0] sum;
  logic [modexp_pkg::WIDTH:0] sum_red;
  logic                       m_zero;

  // one multiplier bit per cycle, MSB first: r = 2r + a*bit, reduced mod m
  always_comb begin
    m_zero  = (m == '0);
    dbl     = {r, 1'b0};
    dbl_red = dbl;
    if (!m_zero && (dbl >= {1'b0, m})) begin
      dbl_red = dbl - {1'b0, m};
    end
    sum = {1'b0, dbl_red[modexp_pkg::WIDTH-1:0]} +
          (bq[modexp_pkg::WIDTH-1] ? {1'b0, aq} : '0);
    sum_red = sum;
    if (!m_zero && (sum >= {1'b0, m})) begin
      sum_red = sum - {1'b0, m};
    end
    r_next = sum_red[modexp_pkg::WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= modexp_pkg::CNT_W'(modexp_pkg::WIDTH);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == modexp_pkg::CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      aq <= a;
      bq <= b;
      r  <= '0;
    end else if (active) begin
      r  <= r_next;
      bq <= {bq[modexp_pkg::WIDTH-2:0], 1'b0};
    end
  end

  assign p = r;

endmodule

// ===== src/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// One word at a time; busy is high until the result is shown, the next start may
// come in the cycle done is high. Each exponent bit up to the highest set one costs
// one pass of the two bit-serial modular multipliers, after a first reduction pass
// of the base; a zero exponent gives only the reduction pass.
// Synchronous reset: idle, no result pending, modulus set to 1.
module modular_exponentiation_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                modulus_we,
  input  modexp_pkg::word_t   modulus,
  input  logic                start,
  input  modexp_pkg::word_t   base,
  input  modexp_pkg::word_t   exponent,
  output logic                busy,
  output logic                done,
  output modexp_pkg::word_t   result
);

  modexp_pkg::state_t state;
  modexp_pkg::word_t  m;
  modexp_pkg::word_t  x;
  modexp_pkg::word_t  acc;
  modexp_pkg::word_t  y;
  modexp_pkg::word_t  one_mod;
  modexp_pkg::word_t  mul0_a;
  modexp_pkg::word_t  mul0_b;
  modexp_pkg::word_t  p0;
  modexp_pkg::word_t  p1;
  logic               mul0_start;
  logic               mul1_start;
  logic               done0;
  logic               done1;
  logic               accept;

  assign busy       = (state != modexp_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign one_mod    = modexp_pkg::WIDTH'(m != modexp_pkg::WIDTH'(1));
  assign mul0_start = accept || (state == modexp_pkg::S_LOOP);
  assign mul1_start = (state == modexp_pkg::S_LOOP);
  assign mul0_a     = busy ? acc : one_mod;
  assign mul0_b     = busy ? x : base;

  modexp_mulmod u_mul0 (
    .clk   (clk),
    .rst   (rst),
    .start (mul0_start),
    .a     (mul0_a),
    .b     (mul0_b),
    .m     (m),
    .done  (done0),
    .p     (p0)
  );

  modexp_mulmod u_mul1 (
    .clk   (clk),
    .rst   (rst),
    .start (mul1_start),
    .a     (x),
    .b     (x),
    .m     (m),
    .done  (done1),
    .p     (p1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::S_IDLE;
      done  <= 1'b0;
      m     <= modexp_pkg::WIDTH'(1);
    end else begin
      done <= 1'b0;
      if (modulus_we) begin
        m <= modulus;
      end
      unique case (state)
        modexp_pkg::S_IDLE: begin
          if (accept) begin
            state <= modexp_pkg::S_RED;
          end
        end
        modexp_pkg::S_RED: begin
          if (done0) begin
            if (y == '0) begin
              state <= modexp_pkg::S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= modexp_pkg::S_LOOP;
            end
          end
        end
        modexp_pkg::S_LOOP: begin
          state <= modexp_pkg::S_MUL;
        end
        modexp_pkg::S_MUL: begin
          if (done0 && done1) begin
            if ((y >> 1) == '0) begin
              state <= modexp_pkg::S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= modexp_pkg::S_LOOP;
            end
          end
        end
        default: state <= modexp_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      modexp_pkg::S_IDLE: begin
        if (accept) begin
          y   <= exponent;
          acc <= one_mod;
        end
      end
      modexp_pkg::S_RED: begin
        if (done0) begin
          x <= p0;
          if (y == '0) begin
            result <= modexp_pkg::WIDTH'(1);
          end
        end
      end
      modexp_pkg::S_LOOP: begin
      end
      modexp_pkg::S_MUL: begin
        if (done0 && done1) begin
          if (y[0]) begin
            acc <= p0;
          end
          x <= p1;
          y <= y >> 1;
          if ((y >> 1) == '0) begin
            result <= y[0] ? p0 : acc;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/modexp_checker.sv =====
`timescale 1ns / 1ps
module modexp_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input modexp_pkg::word_t   exponent,
  input modexp_pkg::word_t   result
);

  // an accepted word keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // a result only appears once the block has gone idle
  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // the end of a busy period always delivers a result
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

  // single-cycle result strobe
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // zero exponent yields one after the reduction pass
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (exponent == '0)) |-> ##34 (done && (result == 1)))
    else $error("zero exponent did not give one");

endmodule

bind modular_exponentiation_top modexp_checker u_modexp_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .exponent (exponent),
  .result   (result)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 1200;
  localparam int DW          = 2 * modexp_pkg::WIDTH;

  typedef struct {
    modexp_pkg::word_t base;
    modexp_pkg::word_t exponent;
    modexp_pkg::word_t result;
  } modpow_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              modulus_we = 1'b0;
  modexp_pkg::word_t modulus = '0;
  logic              start = 1'b0;
  modexp_pkg::word_t base = '0;
  modexp_pkg::word_t exponent = '0;
  logic              busy;
  logic              done;
  modexp_pkg::word_t result;

  modpow_t           expected_results[$];
  modexp_pkg::word_t cur_modulus = 1;
  int                mismatches = 0;
  int                stall_cycles = 0;
  bit                bursts_on = 1'b1;

  modular_exponentiation_top uut (
    .clk        (clk),
    .rst        (rst),
    .modulus_we (modulus_we),
    .modulus    (modulus),
    .start      (start),
    .base       (base),
    .exponent   (exponent),
    .busy       (busy),
    .done       (done),
    .result     (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // right-to-left square-and-multiply; modulus 0 means wrap at WIDTH bits
  function automatic modexp_pkg::word_t modpow(input modexp_pkg::word_t b,
                                               input modexp_pkg::word_t e,
                                               input modexp_pkg::word_t m);
    logic [DW-1:0]     x;
    logic [DW-1:0]     acc;
    modexp_pkg::word_t y;
    x = DW'(b);
    acc = DW'(1);
    y = e;
    if (m != 0) x = x % m;
    while (y != 0) begin
      if (y[0]) begin
        if (m != 0) acc = ((acc % m) * x) % m;
        else acc = DW'(modexp_pkg::word_t'(acc * x));
      end
      y = y >> 1;
      if (m != 0) x = (x * x) % m;
      else x = DW'(modexp_pkg::word_t'(x * x));
    end
    return acc[modexp_pkg::WIDTH-1:0];
  endfunction

  function automatic modexp_pkg::word_t pick_base(input modexp_pkg::word_t m);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return modexp_pkg::word_t'(1);
      2: return m - 1;
      3: return m;
      4: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic modexp_pkg::word_t pick_exponent();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 3);
      1: return '1;
      2, 3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input modexp_pkg::word_t b, input modexp_pkg::word_t e);
    start <= 1'b1;
    base <= b;
    exponent <= e;
    do @(posedge clk); while (busy);
    expected_results.push_back('{b, e, modpow(b, e, cur_modulus)});
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1)) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_modulus(input modexp_pkg::word_t m);
    wait_all_results();
    modulus_we <= 1'b1;
    modulus <= m;
    @(posedge clk);
    cur_modulus = m;
    modulus_we <= 1'b0;
    modulus <= $urandom;
    @(posedge clk);
  endtask

  task automatic test_reset_value();
    send_word(5, 0);
    send_word(7, 3);
    send_word('1, '1);
  endtask

  task automatic test_corner_cases();
    set_modulus('1);
    send_word('1, 1);
    send_word(32'hFFFF_FFFE, '1);
    send_word(0, 0);
    send_word(0, 5);
    send_word(1, '1);
    set_modulus(32'hFFFF_FFFB);
    send_word(32'hFFFF_FFFA, 2);
    send_word(32'hFFFF_FFFB, 7);
    send_word(32'h1234_5678, 32'hFFFF_FFFA);
    set_modulus(2);
    send_word(3, '1);
    send_word(0, '1);
    set_modulus(46349);
    send_word(46348, 2);
    send_word(32'hDEAD_BEEF, 32'h8000_0000);
    set_modulus(1);
    send_word(9, 0);
    send_word(9, 1);
    set_modulus(0);
    send_word(3, 20);
    send_word(2, 32);
    send_word('1, '1);
  endtask

  task automatic test_random_moduli();
    modexp_pkg::word_t m;
    for (int k = 0; k < 10; k++) begin
      case (k)
        0: m = $urandom;
        1: m = '1;
        2: m = $urandom_range(2, 60);
        3: m = 32'hFFFF_FFFB;
        4: m = {1'b1, 31'($urandom)};
        5: m = 46349;
        6: m = 1;
        7: m = 0;
        8: m = $urandom | 1;
        default: m = ($urandom >> $urandom_range(8, 24)) | 2;
      endcase
      set_modulus(m);
      repeat (22) begin
        send_word(pick_base(m), pick_exponent());
        if ($urandom_range(0, 29) == 0) wait_all_results();
      end
    end
  endtask

  task automatic test_pause_until_empty();
    set_modulus($urandom);
    repeat (5) send_word(pick_base(cur_modulus), pick_exponent());
    wait_all_results();
    repeat (5) send_word(pick_base(cur_modulus), pick_exponent());
  endtask

  task automatic test_back_to_back();
    bursts_on = 1'b0;
    set_modulus($urandom);
    repeat (40) send_word(pick_base(cur_modulus), pick_exponent());
  endtask

  always @(posedge clk) begin
    modpow_t exp_word;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h at %0t", result, $realtime);
      end else begin
        exp_word = expected_results.pop_front();
        if (result !== exp_word.result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: base %h exponent %h modulus %h expected %h actual %h",
                     exp_word.base, exp_word.exponent, cur_modulus, exp_word.result,
                     result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_value();
    test_corner_cases();
    test_random_moduli();
    test_pause_until_empty();
    test_back_to_back();
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
